// ----- rtl/core/sws_pkg.sv -----
// Shared types, constants and helpers of the sliding window sender.
// Used by the slot cell, the top level and the port checker.
package sws_pkg;

	localparam int WINDOW_SLOTS = 31;
	localparam int SLOT_W = 5;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
	localparam logic [9:0] MAX_CHUNK = 10'd512;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [4:0] INIT_WIN_RST = 5'd1;
	localparam logic [4:0] CREDIT_MAX = 5'd31;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_ACK  = 2'd1,
		OP_SEND = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_STATUS = 3'd0,
		ACT_SEND   = 3'd1,
		ACT_RESEND = 3'd2,
		ACT_REFUSE = 3'd3,
		ACT_ACK    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT,
		ST_STATUS
	} state_t;

	typedef enum logic {
		CFG_TIMEOUT = 1'b0,
		CFG_INIT_WIN = 1'b1
	} cfg_idx_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		op_t         op;
		logic [7:0]  ack_seq;
		logic [4:0]  wmax;
		logic [15:0] timeout;
		logic        step;
		logic        alloc;
		logic        kill;
		logic [7:0]  new_seq;
		logic [9:0]  new_len;
	} cell_cmd_t;

	// Response of the cell that holds the scan token; zero from all others.
	typedef struct packed {
		logic       hit;
		logic       free;
		logic [7:0] seq;
		logic [9:0] len;
	} cell_resp_t;

	function automatic logic [4:0] clamp_window(input logic [4:0] w);
		return (w > 5'(WINDOW_SLOTS)) ? 5'(WINDOW_SLOTS) : w;
	endfunction

endpackage

// ----- rtl/core/sws_cell.sv -----
// One slot of the outstanding packet table, a link of the scan chain.
// Depends on sws_pkg for the command and response structs.
module sws_cell import sws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  logic       tok_in,
	output logic       tok_out,
	output cell_resp_t resp
);

	logic        valid_q;
	logic        tok_q;
	logic [7:0]  seq_q;
	logic [9:0]  len_q;
	logic [15:0] age_q;
	logic [15:0] age_inc;
	logic [7:0]  seq_dist;
	logic        timed;
	logic        acked;
	logic        act;

	always_comb begin
		age_inc = (age_q == 16'hFFFF) ? age_q : age_q + 16'd1;
		seq_dist = cmd.ack_seq - seq_q;
		timed = age_inc > cmd.timeout;
		acked = (seq_dist != 8'd0) && ({3'b000, cmd.wmax} >= seq_dist);
		act = tok_q && valid_q;
		resp.hit = act && (((cmd.op == OP_TICK) && timed) || ((cmd.op == OP_ACK) && acked));
		resp.free = tok_q && !valid_q;
		resp.seq = tok_q ? seq_q : 8'd0;
		resp.len = tok_q ? len_q : 10'd0;
		tok_out = tok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			if (cmd.alloc && tok_q)
				valid_q <= 1'b1;
			else if (cmd.step && act && (cmd.op == OP_ACK) && acked)
				valid_q <= 1'b0;
			// pass the token down the chain
			if (cmd.kill)
				tok_q <= 1'b0;
			else if (cmd.step)
				tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc && tok_q) begin
			seq_q <= cmd.new_seq;
			len_q <= cmd.new_len;
			age_q <= 16'd0;
		end else if (cmd.step && act && (cmd.op == OP_TICK)) begin
			age_q <= timed ? 16'd0 : age_inc;
		end
	end

endmodule

// ----- rtl/core/sliding_window_sender.sv -----
// Sender window controller: a chain of slot cells and the scan sequencer.
// Depends on sws_pkg and sws_cell.
//
// Each item is accepted, then scanned where its op needs it, then its closing
// results leave. A scan token walks the chain of 31 slot cells one cell per
// cycle while no resend waits for the output register, for ticks (ageing,
// resends), acknowledgements (freeing) and send requests (lowest free slot
// below the window maximum, stopping early when found). A send refused at once
// skips the scan, and an unused op goes straight to its status result. Resends
// leave through the output register during the scan; a tick's scan holds while
// a resend waits for the output register, and each closing result waits until
// the output register can take it. Configuration registers are always ready.
module sliding_window_sender import sws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  ack_seq,
	input  logic [4:0]  ack_window,
	input  logic [9:0]  chunk_length,
	input  logic        chunk_is_final,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [4:0]  slot_index,
	output logic [7:0]  seq_out,
	output logic [9:0]  length_out,
	output logic [4:0]  window_out,
	output logic [4:0]  credit_now,
	output logic        finished,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	state_t      state_q, state_d;
	logic [SLOT_W-1:0] idx_q;
	op_t         op_q;
	logic [7:0]  ack_seq_q;
	logic [9:0]  len_q;
	logic        final_q;
	logic [15:0] timeout_q;
	logic [4:0]  credit_q;
	logic [4:0]  wmax_q;
	logic        adj_q;
	logic [7:0]  next_seq_q;
	logic        end_seen_q;
	logic        found_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [7:0]  pend_seq_q;
	logic [4:0]  pend_win_q;

	logic        out_valid_q;
	logic [2:0]  action_q;
	logic [4:0]  slot_q;
	logic [7:0]  seq_q;
	logic [9:0]  length_q;
	logic [4:0]  window_q;
	logic [4:0]  credit_out_q;
	logic        finished_q;
	logic        last_q;

	cell_cmd_t   cmd;
	cell_resp_t  resp;
	cell_resp_t  cell_resp [WINDOW_SLOTS];
	logic [WINDOW_SLOTS:0] tok;

	logic        accept;
	logic        can_load;
	logic        load;
	logic [2:0]  ld_action;
	logic [4:0]  ld_slot;
	logic [7:0]  ld_seq;
	logic [9:0]  ld_len;
	logic [4:0]  ld_win;
	logic        ld_last;
	logic        step;
	logic        alloc;
	logic        kill;
	logic        head_tok;
	logic        scan_end_refuse;
	logic        early_refuse;
	logic [6:0]  adj_sum;
	logic [6:0]  adj_c;
	logic [9:0]  sat_len;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign sat_len = (chunk_length > MAX_CHUNK) ? MAX_CHUNK : chunk_length;

	always_comb begin
		cmd.op = op_q;
		cmd.ack_seq = ack_seq_q;
		cmd.wmax = wmax_q;
		cmd.timeout = timeout_q;
		cmd.step = step;
		cmd.alloc = alloc;
		cmd.kill = kill;
		cmd.new_seq = next_seq_q;
		cmd.new_len = len_q;
	end

	assign tok[0] = head_tok;

	for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
		sws_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.resp    (cell_resp[g])
		);
	end

	// only the token holder answers, so an OR picks its response
	always_comb begin
		resp = '0;
		for (int i = 0; i < WINDOW_SLOTS; i++)
			resp = resp | cell_resp[i];
	end

	always_comb begin
		adj_sum = {2'b00, credit_q} + {2'b00, ack_window};
		if (adj_sum < {2'b00, wmax_q})
			adj_c = 7'd0;
		else
			adj_c = adj_sum - {2'b00, wmax_q};
		if (adj_c > {2'b00, CREDIT_MAX})
			adj_c = {2'b00, CREDIT_MAX};
	end

	always_comb begin
		state_d = state_q;
		step = 1'b0;
		alloc = 1'b0;
		kill = 1'b0;
		head_tok = 1'b0;
		load = 1'b0;
		ld_action = ACT_STATUS;
		ld_slot = 5'd0;
		ld_seq = 8'd0;
		ld_len = 10'd0;
		ld_win = 5'd0;
		ld_last = 1'b0;
		scan_end_refuse = 1'b0;
		early_refuse = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					step = 1'b1;
					case (op_t'(op))
						OP_TICK, OP_ACK: begin
							head_tok = 1'b1;
							state_d = ST_SCAN;
						end
						OP_SEND: begin
							if (credit_q == 5'd0 || end_seen_q || wmax_q == 5'd0) begin
								early_refuse = 1'b1;
								state_d = ST_RESULT;
							end else begin
								head_tok = 1'b1;
								state_d = ST_SCAN;
							end
						end
						default: state_d = ST_STATUS;
					endcase
				end
			end
			ST_SCAN: begin
				case (op_q)
					OP_TICK: begin
						// hold the scan while a resend waits for the output register
						if (!resp.hit || can_load)
							step = 1'b1;
						if (resp.hit && can_load) begin
							load = 1'b1;
							ld_action = ACT_RESEND;
							ld_slot = idx_q;
							ld_seq = resp.seq;
							ld_len = resp.len;
						end
						if (step && idx_q == LAST_SLOT)
							state_d = ST_STATUS;
					end
					OP_ACK: begin
						step = 1'b1;
						if (idx_q == LAST_SLOT)
							state_d = ST_RESULT;
					end
					default: begin
						if (resp.free && ({1'b0, idx_q} < {1'b0, wmax_q})) begin
							alloc = 1'b1;
							kill = 1'b1;
							state_d = ST_RESULT;
						end else if (idx_q == LAST_SLOT ||
								({1'b0, idx_q} + 6'd1 >= {1'b0, wmax_q})) begin
							kill = 1'b1;
							scan_end_refuse = 1'b1;
							state_d = ST_RESULT;
						end else begin
							step = 1'b1;
						end
					end
				endcase
			end
			ST_RESULT: begin
				if (can_load) begin
					load = 1'b1;
					if (op_q == OP_ACK) begin
						ld_action = ACT_ACK;
						ld_seq = ack_seq_q;
						ld_win = wmax_q;
					end else if (found_q) begin
						ld_action = ACT_SEND;
						ld_slot = pend_slot_q;
						ld_seq = pend_seq_q;
						ld_len = len_q;
						ld_win = pend_win_q;
					end else begin
						ld_action = ACT_REFUSE;
					end
					state_d = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (can_load) begin
					load = 1'b1;
					ld_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			credit_q <= clamp_window(INIT_WIN_RST);
			wmax_q <= clamp_window(INIT_WIN_RST);
			adj_q <= 1'b0;
			next_seq_q <= 8'd0;
			end_seen_q <= 1'b0;
			idx_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TIMEOUT: timeout_q <= cfg_data;
					CFG_INIT_WIN: begin
						credit_q <= clamp_window(cfg_data[4:0]);
						wmax_q <= clamp_window(cfg_data[4:0]);
					end
					default: ;
				endcase
			end
			if (accept) begin
				idx_q <= '0;
				if (op_t'(op) == OP_ACK && ack_window != wmax_q && !adj_q) begin
					credit_q <= clamp_window(adj_c[4:0]);
					wmax_q <= clamp_window(ack_window);
					adj_q <= 1'b1;
				end
			end else if (state_q == ST_SCAN && step) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (state_q == ST_SCAN && op_q == OP_ACK && resp.hit && credit_q != CREDIT_MAX)
				credit_q <= credit_q + 5'd1;
			if (early_refuse || scan_end_refuse)
				found_q <= 1'b0;
			if (alloc) begin
				found_q <= 1'b1;
				credit_q <= credit_q - 5'd1;
				next_seq_q <= next_seq_q + 8'd1;
				if (final_q)
					end_seen_q <= 1'b1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(op);
			ack_seq_q <= ack_seq;
			len_q <= sat_len;
			final_q <= chunk_is_final;
		end
		if (alloc) begin
			pend_slot_q <= idx_q;
			pend_seq_q <= next_seq_q;
			pend_win_q <= credit_q;
		end
		if (load) begin
			action_q <= ld_action;
			slot_q <= ld_slot;
			seq_q <= ld_seq;
			length_q <= ld_len;
			window_q <= ld_win;
			credit_out_q <= credit_q;
			finished_q <= end_seen_q && (credit_q == wmax_q);
			last_q <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign slot_index = slot_q;
	assign seq_out = seq_q;
	assign length_out = length_q;
	assign window_out = window_q;
	assign credit_now = credit_out_q;
	assign finished = finished_q;
	assign last_result = last_q;

endmodule

// ----- rtl/core/sws_checker.sv -----
// Port-level checks of the sliding window sender, bound to the top level.
// Depends on sws_pkg for the action codes.
module sws_checker import sws_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] action,
	input logic [4:0] window_out,
	input logic       last_result
);

	// the closing result of an item is always the status result
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_result |-> action == ACT_STATUS)
		else $error("closing result is not a status result");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_STATUS |-> last_result)
		else $error("status result not flagged last");

	a_send_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_SEND |-> window_out != 5'd0)
		else $error("send issued without credit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action))
		else $error("stalled transaction dropped");

endmodule

bind sliding_window_sender sws_checker u_sws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.action      (action),
	.window_out  (window_out),
	.last_result (last_result)
);

// ----- bench/tb_sliding_window_sender.sv -----
// Self-checking regression for the sliding window sender.
// Depends on sws_pkg and the sliding_window_sender RTL.
`timescale 1ns / 1ps

module tb_sliding_window_sender;
	import sws_pkg::*;

	typedef struct {
		action_t    act;
		logic [4:0] slot;
		logic [7:0] seq;
		logic [9:0] len;
		logic [4:0] win;
		logic [4:0] credit;
		logic       fin;
		logic       last;
	} window_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid, in_stall;
	logic [1:0]  op;
	logic [7:0]  ack_seq;
	logic [4:0]  ack_window;
	logic [9:0]  chunk_length;
	logic        chunk_is_final;
	logic        out_valid, out_stall;
	logic [2:0]  action;
	logic [4:0]  slot_index, window_out, credit_now;
	logic [7:0]  seq_out;
	logic [9:0]  length_out;
	logic        finished, last_result;
	logic        cfg_valid, cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	sliding_window_sender uut (.*);

	always #5 clk = ~clk;

	// mirror of the block state
	logic        mir_valid [WINDOW_SLOTS];
	logic [7:0]  mir_seq [WINDOW_SLOTS];
	logic [9:0]  mir_len [WINDOW_SLOTS];
	logic [15:0] mir_age [WINDOW_SLOTS];
	logic [15:0] mir_timeout;
	logic [4:0]  mir_credit, mir_wmax;
	logic        mir_adjusted, mir_end;
	logic [7:0]  mir_next_seq;

	window_result_t pending_results[$];
	int errors = 0;
	int send_gap_pct = 30;
	int out_stall_pct = 30;
	int stall_left = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		return ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
	endfunction

	// Compute the results of one accepted transaction and advance the mirror.
	task automatic predict_window(input op_t o, input logic [7:0] aseq,
			input logic [4:0] awin, input logic [9:0] clen, input logic cfin);
		window_result_t r[$];
		window_result_t e;
		int c;
		int fslot;
		logic [7:0] d;
		logic fin;
		e = '{ACT_STATUS, 0, 0, 0, 0, 0, 0, 0};
		case (o)
			OP_TICK: begin
				for (int i = 0; i < WINDOW_SLOTS; i++) begin
					if (!mir_valid[i])
						continue;
					if (mir_age[i] != 16'hFFFF)
						mir_age[i]++;
					if (mir_age[i] > mir_timeout) begin
						e = '{ACT_RESEND, 5'(i), mir_seq[i], mir_len[i], 0, 0, 0, 0};
						r.push_back(e);
						mir_age[i] = 0;
					end
				end
			end
			OP_ACK: begin
				if (awin != mir_wmax && !mir_adjusted) begin
					c = int'(mir_credit) + int'(awin) - int'(mir_wmax);
					if (c < 0)
						c = 0;
					if (c > WINDOW_SLOTS)
						c = WINDOW_SLOTS;
					mir_credit = 5'(c);
					mir_wmax = (awin > 5'(WINDOW_SLOTS)) ? 5'(WINDOW_SLOTS) : awin;
					mir_adjusted = 1'b1;
				end
				for (int i = 0; i < WINDOW_SLOTS; i++) begin
					if (!mir_valid[i])
						continue;
					d = aseq - mir_seq[i];
					if (d >= 1 && d <= mir_wmax) begin
						mir_valid[i] = 1'b0;
						if (mir_credit != CREDIT_MAX)
							mir_credit++;
					end
				end
				e = '{ACT_ACK, 0, aseq, 0, mir_wmax, 0, 0, 0};
				r.push_back(e);
			end
			OP_SEND: begin
				fslot = -1;
				if (mir_credit > 0 && !mir_end)
					for (int i = 0; i < WINDOW_SLOTS && i < mir_wmax; i++)
						if (!mir_valid[i]) begin
							fslot = i;
							break;
						end
				if (fslot < 0) begin
					e = '{ACT_REFUSE, 0, 0, 0, 0, 0, 0, 0};
				end else begin
					e = '{ACT_SEND, 5'(fslot), mir_next_seq,
						(clen > MAX_CHUNK) ? MAX_CHUNK : clen, mir_credit, 0, 0, 0};
					mir_valid[fslot] = 1'b1;
					mir_seq[fslot] = mir_next_seq;
					mir_len[fslot] = e.len;
					mir_age[fslot] = 0;
					mir_next_seq++;
					mir_credit--;
					if (cfin)
						mir_end = 1'b1;
				end
				r.push_back(e);
			end
			default: ;
		endcase
		e = '{ACT_STATUS, 0, 0, 0, 0, 0, 0, 0};
		r.push_back(e);
		fin = mir_end && (mir_credit == mir_wmax);
		foreach (r[i]) begin
			r[i].credit = mir_credit;
			r[i].fin = fin;
			r[i].last = (i == r.size() - 1);
			pending_results.push_back(r[i]);
		end
	endtask

	task automatic send_item(input op_t o, input logic [7:0] aseq, input logic [4:0] awin,
			input logic [9:0] clen, input logic cfin);
		int gap;
		gap = pick_gap(send_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		ack_seq <= aseq;
		ack_window <= awin;
		chunk_length <= clen;
		chunk_is_final <= cfin;
		do @(posedge clk); while (in_stall);
		predict_window(o, aseq, awin, clen, cfin);
	endtask

	// Hold the sender until every expected transaction is back, then let the block settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_TIMEOUT) begin
			mir_timeout = value;
		end else begin
			mir_credit = (value[4:0] > 5'(WINDOW_SLOTS)) ? 5'(WINDOW_SLOTS) : value[4:0];
			mir_wmax = mir_credit;
		end
		@(posedge clk);
	endtask

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		window_result_t e;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result, action", action, 0);
			end else begin
				e = pending_results.pop_front();
				if (action !== e.act) report("action", action, e.act);
				if (slot_index !== e.slot) report("slot_index", slot_index, e.slot);
				if (seq_out !== e.seq) report("seq_out", seq_out, e.seq);
				if (length_out !== e.len) report("length_out", length_out, e.len);
				if (window_out !== e.win) report("window_out", window_out, e.win);
				if (credit_now !== e.credit) report("credit_now", credit_now, e.credit);
				if (finished !== e.fin) report("finished", finished, e.fin);
				if (last_result !== e.last) report("last_result", last_result, e.last);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < out_stall_pct) begin
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_reset_defaults();
		send_item(OP_SEND, 0, 0, 10'd0, 1'b0);
		send_item(OP_SEND, 0, 0, 10'd5, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_ACK, 8'd1, 5'd1, 0, 1'b0);
		send_item(OP_NONE, 8'hFF, 5'h1F, 10'h3FF, 1'b1);
		drain_results();
	endtask

	task automatic test_full_window();
		write_reg(CFG_TIMEOUT, 16'd2);
		write_reg(CFG_INIT_WIN, 16'hFFFF);
		send_gap_pct = 0;
		out_stall_pct = 0;
		for (int i = 0; i < 31; i++)
			send_item(OP_SEND, 0, 0, (i == 0) ? 10'h3FF : 10'(i * 33), 1'b0);
		send_item(OP_SEND, 0, 0, 10'd512, 1'b0);
		send_gap_pct = 30;
		out_stall_pct = 30;
		repeat (3) send_item(OP_TICK, 0, 0, 0, 1'b0);
		// first differing window shrinks the maximum and recomputes the credit; the second is ignored
		send_item(OP_ACK, 8'd20, 5'd20, 0, 1'b0);
		send_item(OP_ACK, 8'd25, 5'd5, 0, 1'b0);
		send_item(OP_ACK, 8'd0, 5'd20, 0, 1'b0);
		drain_results();
	endtask

	task automatic test_timeout_zero();
		write_reg(CFG_TIMEOUT, 16'd0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		drain_results();
		write_reg(CFG_INIT_WIN, 16'd0);
		send_item(OP_SEND, 0, 0, 10'd1, 1'b0);
		drain_results();
	endtask

	task automatic run_traffic(input int n, input logic [15:0] tmo, input logic [4:0] win,
			input int gap_pct, input int stall_pct, input logic allow_final);
		logic [7:0] aseq;
		logic [4:0] awin;
		int pick;
		write_reg(CFG_TIMEOUT, tmo);
		write_reg(CFG_INIT_WIN, {11'($urandom), win});
		send_gap_pct = gap_pct;
		out_stall_pct = stall_pct;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (k == n / 2)
				drain_results();
			if (pick < 45) begin
				send_item(OP_SEND, 8'($urandom), 5'($urandom),
					($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 512)),
					allow_final && ($urandom_range(29) == 0));
			end else if (pick < 75) begin
				aseq = mir_next_seq - 8'($urandom_range(0, 4));
				awin = mir_wmax;
				if ($urandom_range(9) == 0) aseq = 8'($urandom);
				if ($urandom_range(9) == 0) awin = 5'($urandom);
				send_item(OP_ACK, aseq, awin, 10'($urandom), 1'($urandom));
			end else if (pick < 95) begin
				send_item(OP_TICK, 8'($urandom), 5'($urandom), 10'($urandom), 1'($urandom));
			end else begin
				send_item(OP_NONE, 8'($urandom), 5'($urandom), 10'($urandom), 1'($urandom));
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_NONE;
		ack_seq <= '0;
		ack_window <= '0;
		chunk_length <= '0;
		chunk_is_final <= 1'b0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= '0;
		foreach (mir_valid[i]) begin
			mir_valid[i] = 1'b0;
			mir_seq[i] = '0;
			mir_len[i] = '0;
			mir_age[i] = '0;
		end
		mir_timeout = TIMEOUT_RST;
		mir_credit = INIT_WIN_RST;
		mir_wmax = INIT_WIN_RST;
		mir_adjusted = 1'b0;
		mir_end = 1'b0;
		mir_next_seq = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_full_window();
		test_timeout_zero();
		run_traffic(75, 16'd1, 5'd31, 0, 0, 1'b0);
		run_traffic(75, 16'($urandom_range(2, 6)), 5'($urandom_range(2, 30)), 30, 30, 1'b0);
		run_traffic(75, 16'hFFFF, 5'd1, 40, 40, 1'b0);
		run_traffic(75, 16'd3, 5'd16, 30, 30, 1'b1);

		if (pending_results.size() != 0)
			report("results never received", 0, pending_results.size());
		if (errors == 0)
			$display("sliding_window_sender regression: pass");
		else
			$display("sliding_window_sender regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("sliding_window_sender regression: fail");
		$finish;
	end

endmodule

// ----- sliding_window_sender.f -----
rtl/core/sws_pkg.sv
rtl/core/sws_cell.sv
rtl/core/sliding_window_sender.sv
rtl/core/sws_checker.sv
bench/tb_sliding_window_sender.sv
